@@ src/spectrum_max_peak_finder_assert.svh @@
// Assertion macros shared by the peak finder modules.
`ifndef SPECTRUM_MAX_PEAK_FINDER_ASSERT_SVH
`define SPECTRUM_MAX_PEAK_FINDER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SMPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define SMPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/smpf_pkg.sv @@
// Types, constants and the arctangent table of the spectrum peak finder.
`timescale 1ns / 1ps
`default_nettype none

package smpf_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W  = 16;
    localparam int POWER_W   = 32;
    localparam int BIN_W     = 12;
    localparam int LEN_W     = 13;
    localparam int SBIN_W    = 14;
    localparam int PHASE_W   = 16;

    // Largest frame the search window honours.
    localparam int MAX_FRAME = 4096;

    // CORDIC datapath: I/Q scaled by 2^8, angle with pi = 2^23.
    localparam int XY_W      = 27;
    localparam int Z_W       = 26;
    localparam int ANGLE_FRAC = 8;
    localparam logic signed [Z_W-1:0] ANGLE_PI = 26'sd8388608;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_BINS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_POS_BIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_NEG_BIN   = 3'd5;

    // Configuration register set.
    typedef struct packed {
        logic [LEN_W-1:0]   frame_length;
        logic [BIN_W-1:0]   guard_bins;
        logic [POWER_W-1:0] power_threshold;
        logic               cut_enable;
        logic [LEN_W-1:0]   upper_pos_bin;
        logic [LEN_W-1:0]   lower_neg_bin;
    } t_cfg;

    // One finished frame search, handed from the front to the back.
    typedef struct packed {
        logic                       found;
        logic [BIN_W-1:0]           idx;
        logic [POWER_W-1:0]         power;
        logic signed [SAMPLE_W-1:0] i;
        logic signed [SAMPLE_W-1:0] q;
    } t_rec;

    // atan(2^-k) with pi = 2^23.
    function automatic logic [21:0] f_atan(input logic [4:0] k);
        logic [21:0] v;
        unique case (k)
            5'd0:  v = 22'd2097152;
            5'd1:  v = 22'd1238021;
            5'd2:  v = 22'd654136;
            5'd3:  v = 22'd332050;
            5'd4:  v = 22'd166670;
            5'd5:  v = 22'd83415;
            5'd6:  v = 22'd41718;
            5'd7:  v = 22'd20860;
            5'd8:  v = 22'd10430;
            5'd9:  v = 22'd5215;
            5'd10: v = 22'd2608;
            5'd11: v = 22'd1304;
            5'd12: v = 22'd652;
            5'd13: v = 22'd326;
            5'd14: v = 22'd163;
            5'd15: v = 22'd81;
            5'd16: v = 22'd41;
            5'd17: v = 22'd20;
            5'd18: v = 22'd10;
            5'd19: v = 22'd5;
            5'd20: v = 22'd3;
            5'd21: v = 22'd1;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/smpf_front.sv @@
// Search front end: bin counter, window test, power pipeline and running maximum.
`timescale 1ns / 1ps
`default_nettype none

module smpf_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire smpf_pkg::t_cfg                     i_cfg,
    input  wire logic [smpf_pkg::LEN_W-1:0]         i_frame_len,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic signed [smpf_pkg::SAMPLE_W-1:0] i_sample_i,
    input  wire logic signed [smpf_pkg::SAMPLE_W-1:0] i_sample_q,
    input  wire logic                               i_frame_last,
    output logic                                    o_rec_push,
    output smpf_pkg::t_rec                          o_rec,
    input  wire logic                               i_q_full
);
    import smpf_pkg::*;

    localparam logic [LEN_W-1:0] CNT_MAX = {LEN_W{1'b1}};

    logic [LEN_W-1:0] r_bin_cnt;

    // Stage 1: sample and window decision.
    logic                       r_s1_valid, r_s1_last, r_s1_ok;
    logic [BIN_W-1:0]           r_s1_idx;
    logic signed [SAMPLE_W-1:0] r_s1_i, r_s1_q;

    // Stage 2: squares.
    logic                       r_s2_valid, r_s2_last, r_s2_ok;
    logic [BIN_W-1:0]           r_s2_idx;
    logic signed [SAMPLE_W-1:0] r_s2_i, r_s2_q;
    logic [POWER_W-1:0]         r_s2_sq_i, r_s2_sq_q;

    // Stage 3: power, compared against the running maximum.
    logic                       r_s3_valid, r_s3_last, r_s3_ok;
    logic [BIN_W-1:0]           r_s3_idx;
    logic signed [SAMPLE_W-1:0] r_s3_i, r_s3_q;
    logic [POWER_W-1:0]         r_s3_pw;

    // Running maximum of the current frame.
    logic                       r_best_valid;
    logic [POWER_W-1:0]         r_best_power;
    logic [BIN_W-1:0]           r_best_idx;
    logic signed [SAMPLE_W-1:0] r_best_i, r_best_q;
    logic                       n_best_valid;
    logic [POWER_W-1:0]         n_best_power;
    logic [BIN_W-1:0]           n_best_idx;
    logic signed [SAMPLE_W-1:0] n_best_i, n_best_q;

    logic                       w_stall, w_adv, w_accept;
    logic                       w_lo_ok, w_hi_ok, w_cut, w_ok, w_qual;
    logic signed [POWER_W-1:0]  w_sq_i, w_sq_q;

    // The whole pipeline halts while a frame end waits for room in the queue.
    assign w_stall  = r_s3_valid && r_s3_last && i_q_full;
    assign w_adv    = !w_stall;
    assign o_full   = w_stall;
    assign w_accept = i_push && !w_stall;

    // Window test on the current bin index.
    assign w_lo_ok = r_bin_cnt >= {1'b0, i_cfg.guard_bins};
    assign w_hi_ok = ({1'b0, r_bin_cnt} + {2'b00, i_cfg.guard_bins}) < {1'b0, i_frame_len};
    assign w_cut   = i_cfg.cut_enable && (r_bin_cnt > i_cfg.upper_pos_bin)
                     && (r_bin_cnt < i_cfg.lower_neg_bin);
    assign w_ok    = w_lo_ok && w_hi_ok && !w_cut;

    // Bin counter: restarts after the frame end, saturates on overlong frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (w_accept) begin
            if (i_frame_last) begin
                r_bin_cnt <= '0;
            end else if (r_bin_cnt != CNT_MAX) begin
                r_bin_cnt <= r_bin_cnt + 1'b1;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign w_sq_i = r_s1_i * r_s1_i;
    assign w_sq_q = r_s1_q * r_s1_q;

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= i_frame_last;
            r_s1_ok   <= w_ok;
            r_s1_idx  <= r_bin_cnt[BIN_W-1:0];
            r_s1_i    <= i_sample_i;
            r_s1_q    <= i_sample_q;

            r_s2_last <= r_s1_last;
            r_s2_ok   <= r_s1_ok;
            r_s2_idx  <= r_s1_idx;
            r_s2_i    <= r_s1_i;
            r_s2_q    <= r_s1_q;
            r_s2_sq_i <= w_sq_i;
            r_s2_sq_q <= w_sq_q;

            r_s3_last <= r_s2_last;
            r_s3_ok   <= r_s2_ok;
            r_s3_idx  <= r_s2_idx;
            r_s3_i    <= r_s2_i;
            r_s3_q    <= r_s2_q;
            r_s3_pw   <= r_s2_sq_i + r_s2_sq_q;
        end
    end

    // A bin wins if it lies in the window, clears the threshold and beats every earlier winner.
    assign w_qual = r_s3_ok && (r_s3_pw > i_cfg.power_threshold)
                    && (!r_best_valid || (r_s3_pw > r_best_power));

    always_comb begin
        n_best_valid = r_best_valid;
        n_best_power = r_best_power;
        n_best_idx   = r_best_idx;
        n_best_i     = r_best_i;
        n_best_q     = r_best_q;
        if (w_qual) begin
            n_best_valid = 1'b1;
            n_best_power = r_s3_pw;
            n_best_idx   = r_s3_idx;
            n_best_i     = r_s3_i;
            n_best_q     = r_s3_q;
        end
    end

    // Running maximum, cleared once a frame end has been handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_power <= '0;
            r_best_idx   <= '0;
            r_best_i     <= '0;
            r_best_q     <= '0;
        end else if (r_s3_valid && w_adv) begin
            if (r_s3_last) begin
                r_best_valid <= 1'b0;
                r_best_power <= '0;
                r_best_idx   <= '0;
                r_best_i     <= '0;
                r_best_q     <= '0;
            end else begin
                r_best_valid <= n_best_valid;
                r_best_power <= n_best_power;
                r_best_idx   <= n_best_idx;
                r_best_i     <= n_best_i;
                r_best_q     <= n_best_q;
            end
        end
    end

    // Frame record towards the queue.
    assign o_rec_push  = r_s3_valid && r_s3_last && !i_q_full;
    assign o_rec.found = n_best_valid;
    assign o_rec.idx   = n_best_idx;
    assign o_rec.power = n_best_power;
    assign o_rec.i     = n_best_i;
    assign o_rec.q     = n_best_q;

`include "spectrum_max_peak_finder_assert.svh"

    // A frame end held back by a full queue stays in the last stage.
    `SMPF_ASSERT_NXT(a_front_stall_hold, i_clk, i_rst_n, w_stall, r_s3_valid && r_s3_last)

endmodule

`default_nettype wire

@@ src/smpf_queue.sv @@
// Two-entry queue of frame records between the search front and the phase back end.
`timescale 1ns / 1ps
`default_nettype none

module smpf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire smpf_pkg::t_rec i_rec,
    output logic                o_full,
    input  wire logic           i_pop,
    output smpf_pkg::t_rec      o_rec,
    output logic                o_empty
);
    import smpf_pkg::*;

    t_rec       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`include "spectrum_max_peak_finder_assert.svh"

    `SMPF_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SMPF_ASSERT_IMP(a_queue_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

@@ src/smpf_back.sv @@
// Result back end: iterative CORDIC phase, signed bin and output register.
`timescale 1ns / 1ps
`default_nettype none

module smpf_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [smpf_pkg::LEN_W-1:0]    i_frame_len,
    input  wire smpf_pkg::t_rec                i_rec,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic                               o_peak_found,
    output logic [smpf_pkg::BIN_W-1:0]         o_peak_bin,
    output logic signed [smpf_pkg::SBIN_W-1:0] o_signed_bin,
    output logic [smpf_pkg::POWER_W-1:0]       o_peak_power,
    output logic signed [smpf_pkg::PHASE_W-1:0] o_peak_phase
);
    import smpf_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ITER = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]              r_state;
    logic [STEP_W-1:0]       r_step;
    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic                    r_found, r_zero;
    logic [BIN_W-1:0]        r_idx;
    logic [POWER_W-1:0]      r_pow;
    logic                    r_out_valid;

    logic                    w_load, w_out_free, w_out_write, w_neg;
    logic signed [XY_W-1:0]  w_xi, w_yi, w_dx, w_dy;
    logic signed [Z_W-1:0]   w_atan, w_zr;
    logic [LEN_W-1:0]        w_half;
    logic signed [SBIN_W-1:0] w_sbin;

    assign w_load      = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_pop     = w_load;
    assign w_out_free  = !r_out_valid || i_pop;
    assign w_out_write = (r_state == ST_HOLD) && w_out_free;

    // Start vector: scale by 2^8 and fold the left half-plane by pi.
    assign w_neg = i_rec.i[SAMPLE_W-1];
    assign w_xi  = {{(XY_W-SAMPLE_W-ANGLE_FRAC){i_rec.i[SAMPLE_W-1]}}, i_rec.i,
                    {ANGLE_FRAC{1'b0}}};
    assign w_yi  = {{(XY_W-SAMPLE_W-ANGLE_FRAC){i_rec.q[SAMPLE_W-1]}}, i_rec.q,
                    {ANGLE_FRAC{1'b0}}};

    // One CORDIC micro-rotation per cycle.
    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_atan = $signed({{(Z_W-22){1'b0}}, f_atan(5'(r_step))});

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_state <= ST_ITER;
                        r_step  <= '0;
                    end
                end
                ST_ITER: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_HOLD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_found <= i_rec.found;
            r_zero  <= !i_rec.found || ((i_rec.i == '0) && (i_rec.q == '0));
            r_idx   <= i_rec.idx;
            r_pow   <= i_rec.power;
            r_x     <= w_neg ? -w_xi : w_xi;
            r_y     <= w_neg ? -w_yi : w_yi;
            if (w_neg) begin
                r_z <= i_rec.q[SAMPLE_W-1] ? -ANGLE_PI : ANGLE_PI;
            end else begin
                r_z <= '0;
            end
        end else if (r_state == ST_ITER) begin
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end
        end
    end

    // Angle rounded half up to 16 bits; signed bin split at half the frame.
    assign w_zr   = r_z + Z_W'(1 << (ANGLE_FRAC - 1));
    assign w_half = i_frame_len >> 1;
    assign w_sbin = ({1'b0, r_idx} <= w_half)
                    ? $signed({{(SBIN_W-BIN_W){1'b0}}, r_idx})
                    : $signed({{(SBIN_W-BIN_W){1'b0}}, r_idx} - {1'b0, i_frame_len});

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_write) begin
            o_peak_found <= r_found;
            o_peak_bin   <= r_found ? r_idx : '0;
            o_signed_bin <= r_found ? w_sbin : '0;
            o_peak_power <= r_found ? r_pow : '0;
            o_peak_phase <= r_zero ? '0 : $signed(w_zr[ANGLE_FRAC+PHASE_W-1:ANGLE_FRAC]);
        end
    end

    assign o_empty = !r_out_valid;

`include "spectrum_max_peak_finder_assert.svh"

    // A finished phase is not dropped while the previous result is still waiting.
    `SMPF_ASSERT_NXT(a_back_hold_result, i_clk, i_rst_n,
                     (r_state == ST_HOLD) && r_out_valid && !i_pop, r_state == ST_HOLD)

endmodule

`default_nettype wire

@@ src/spectrum_max_peak_finder.sv @@
// Top level of the spectrum peak finder: configuration registers and the three parts.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------------
//  bins in   push / full               i_sample_i, i_sample_q, i_frame_last
//  results   empty / pop               o_peak_found, o_peak_bin, o_signed_bin,
//                                      o_peak_power, o_peak_phase
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One bin is taken every cycle while full is low; a frame's record leaves the search
// pipeline from its last stage and waits in a two-entry queue. The phase unit works on
// one frame at a time, one CORDIC rotation a cycle, and takes the next record only once
// its result is in the output register; short frames can so fill the queue and raise full.
// Reset is synchronous and active low; it restores the register defaults and empties
// the pipeline, the queue and the output register. The config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_max_peak_finder #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [smpf_pkg::SAMPLE_W-1:0] i_sample_i,
    input  wire logic signed [smpf_pkg::SAMPLE_W-1:0] i_sample_q,
    input  wire logic                                i_frame_last,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     o_peak_found,
    output logic [smpf_pkg::BIN_W-1:0]               o_peak_bin,
    output logic signed [smpf_pkg::SBIN_W-1:0]       o_signed_bin,
    output logic [smpf_pkg::POWER_W-1:0]             o_peak_power,
    output logic signed [smpf_pkg::PHASE_W-1:0]      o_peak_phase,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [smpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [31:0]                         i_cfg_data
);
    import smpf_pkg::*;

    t_cfg             r_cfg;
    logic [LEN_W-1:0] w_frame_len;
    logic             w_rec_push, w_q_full, w_q_empty, w_q_pop;
    t_rec             w_rec_in, w_rec_out;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length    <= 13'd1024;
            r_cfg.guard_bins      <= '0;
            r_cfg.power_threshold <= '0;
            r_cfg.cut_enable      <= 1'b0;
            r_cfg.upper_pos_bin   <= 13'd4096;
            r_cfg.lower_neg_bin   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_LENGTH:    r_cfg.frame_length    <= i_cfg_data[LEN_W-1:0];
                REG_GUARD_BINS:      r_cfg.guard_bins      <= i_cfg_data[BIN_W-1:0];
                REG_POWER_THRESHOLD: r_cfg.power_threshold <= i_cfg_data[POWER_W-1:0];
                REG_CUT_ENABLE:      r_cfg.cut_enable      <= i_cfg_data[0];
                REG_UPPER_POS_BIN:   r_cfg.upper_pos_bin   <= i_cfg_data[LEN_W-1:0];
                REG_LOWER_NEG_BIN:   r_cfg.lower_neg_bin   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective frame length, limited to the largest supported frame.
    assign w_frame_len = (32'(r_cfg.frame_length) > MAX_FRAME) ? LEN_W'(MAX_FRAME)
                                                               : r_cfg.frame_length;

    smpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_frame_len  (w_frame_len),
        .i_push       (push),
        .o_full       (full),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .i_frame_last (i_frame_last),
        .o_rec_push   (w_rec_push),
        .o_rec        (w_rec_in),
        .i_q_full     (w_q_full)
    );

    smpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_rec_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rec   (w_rec_out),
        .o_empty (w_q_empty)
    );

    smpf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_len  (w_frame_len),
        .i_rec        (w_rec_out),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_peak_found (o_peak_found),
        .o_peak_bin   (o_peak_bin),
        .o_signed_bin (o_signed_bin),
        .o_peak_power (o_peak_power),
        .o_peak_phase (o_peak_phase)
    );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench of the spectrum peak finder: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb;
    import smpf_pkg::*;

    // Register indexes past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int     BIN_COUNT_MAX = 8191;
    localparam int     PHASE_STEPS   = 16;
    localparam longint HALF_TURN     = 64'sd8388608;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     RANDOM_ITEMS  = 820;
    localparam int     LONG_FRAME_N    = 16;
    localparam int     LONG_FRAME_BINS = 48;

    // Arctangent of 2^-k with a half turn of 2^23.
    localparam longint ATAN_STEP [0:PHASE_STEPS-1] = '{
        2097152, 1238021, 654136, 332050, 166670, 83415, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    // One frame result as seen on the output ports.
    typedef struct packed {
        logic                      found;
        logic [BIN_W-1:0]          bin;
        logic signed [SBIN_W-1:0]  sbin;
        logic [POWER_W-1:0]        power;
        logic signed [PHASE_W-1:0] phase;
    } t_peak;

    // Scoreboard: tracks the frame search and holds the peaks still to come.
    class peak_scoreboard;
        t_cfg             regs;
        int unsigned      bin_cnt;
        bit               best_ok;
        logic [POWER_W-1:0] best_pw;
        logic [BIN_W-1:0] best_bin;
        longint           best_i;
        longint           best_q;
        t_peak            awaiting[$];
        int               errors;

        function new();
            regs.frame_length    = 13'd1024;
            regs.guard_bins      = '0;
            regs.power_threshold = '0;
            regs.cut_enable      = 1'b0;
            regs.upper_pos_bin   = 13'd4096;
            regs.lower_neg_bin   = '0;
            bin_cnt = 0;
            errors  = 0;
            clear_search();
        endfunction

        function void clear_search();
            best_ok  = 1'b0;
            best_pw  = '0;
            best_bin = '0;
            best_i   = 0;
            best_q   = 0;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) begin
                $display("ERROR at %0t: %s", $realtime, what);
            end
        endfunction

        // A configuration transaction; values are cut to the register width.
        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_FRAME_LENGTH:    regs.frame_length    = d[LEN_W-1:0];
                REG_GUARD_BINS:      regs.guard_bins      = d[BIN_W-1:0];
                REG_POWER_THRESHOLD: regs.power_threshold = d;
                REG_CUT_ENABLE:      regs.cut_enable      = d[0];
                REG_UPPER_POS_BIN:   regs.upper_pos_bin   = d[LEN_W-1:0];
                REG_LOWER_NEG_BIN:   regs.lower_neg_bin   = d[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Vectoring CORDIC on the I/Q pair, angle rounded half up to 16 bits.
        function logic signed [PHASE_W-1:0] cordic_phase(longint ci, longint cq);
            longint x, y, z, dx, dy;
            int     k;
            if (ci == 0 && cq == 0) begin
                return '0;
            end
            x = ci * 256;
            y = cq * 256;
            z = 0;
            // A vector in the left half plane is first turned by half a revolution.
            if (x < 0) begin
                z = (cq >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            for (k = 0; k < PHASE_STEPS; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_STEP[k];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_STEP[k];
                end
            end
            z = (z + 128) >>> 8;
            return z[PHASE_W-1:0];
        endfunction

        // An accepted bin: update the search and, on the last bin, queue the peak.
        function void note_bin(logic signed [SAMPLE_W-1:0] si,
                               logic signed [SAMPLE_W-1:0] sq, logic last);
            longint      pw;
            int unsigned n;
            bit          in_win;
            int          sb;
            t_peak       r;
            n  = (regs.frame_length > MAX_FRAME) ? MAX_FRAME : regs.frame_length;
            pw = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
            in_win = (bin_cnt >= regs.guard_bins) && (bin_cnt + regs.guard_bins < n);
            if (regs.cut_enable && bin_cnt > regs.upper_pos_bin &&
                bin_cnt < regs.lower_neg_bin) begin
                in_win = 1'b0;
            end
            if (in_win && pw > longint'({32'd0, regs.power_threshold}) &&
                (!best_ok || pw > longint'({32'd0, best_pw}))) begin
                best_ok  = 1'b1;
                best_pw  = pw[POWER_W-1:0];
                best_bin = bin_cnt[BIN_W-1:0];
                best_i   = si;
                best_q   = sq;
            end
            if (!last) begin
                if (bin_cnt < BIN_COUNT_MAX) begin
                    bin_cnt++;
                end
                return;
            end
            r = '0;
            if (best_ok) begin
                sb = (best_bin <= n / 2) ? int'(best_bin) : int'(best_bin) - int'(n);
                r.found = 1'b1;
                r.bin   = best_bin;
                r.sbin  = sb[SBIN_W-1:0];
                r.power = best_pw;
                r.phase = cordic_phase(best_i, best_q);
            end
            awaiting.insert(awaiting.size(), r);
            bin_cnt = 0;
            clear_search();
        endfunction

        // A result transaction: compare with the oldest outstanding peak.
        function void check_peak(t_peak got);
            t_peak want;
            if (awaiting.size() == 0) begin
                flag($sformatf("peak result with no frame outstanding: %p", got));
                return;
            end
            want = awaiting.pop_front();
            if (got.found !== want.found || got.bin !== want.bin ||
                got.sbin !== want.sbin || got.power !== want.power ||
                got.phase !== want.phase) begin
                flag({$sformatf("peak mismatch: expected found=%0d bin=%0d sbin=%0d ",
                                want.found, want.bin, want.sbin),
                      $sformatf("power=%0d phase=%0d, got found=%0d bin=%0d sbin=%0d ",
                                want.power, want.phase, got.found, got.bin, got.sbin),
                      $sformatf("power=%0d phase=%0d", got.power, got.phase)});
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [SAMPLE_W-1:0] i_sample_i = '0;
    logic signed [SAMPLE_W-1:0] i_sample_q = '0;
    logic i_frame_last = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic o_peak_found;
    logic [BIN_W-1:0] o_peak_bin;
    logic signed [SBIN_W-1:0] o_signed_bin;
    logic [POWER_W-1:0] o_peak_power;
    logic signed [PHASE_W-1:0] o_peak_phase;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    peak_scoreboard sb;
    bit steady = 1'b0;
    int items_sent = 0;
    int cur_n = 1024;

    spectrum_max_peak_finder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .i_frame_last (i_frame_last),
        .empty        (empty),
        .pop          (pop),
        .o_peak_found (o_peak_found),
        .o_peak_bin   (o_peak_bin),
        .o_signed_bin (o_signed_bin),
        .o_peak_power (o_peak_power),
        .o_peak_phase (o_peak_phase),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // The result side stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        pop <= steady || ($urandom_range(99) >= 29);
    end

    // Every result transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_peak({o_peak_found, o_peak_bin, o_signed_bin, o_peak_power,
                           o_peak_phase});
        end
    end

    // Present one bin, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_bin(input logic signed [SAMPLE_W-1:0] si,
                            input logic signed [SAMPLE_W-1:0] sq, input logic last);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 29) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_sample_i   <= si;
        i_sample_q   <= sq;
        i_frame_last <= last;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sb.note_bin(si, sq, last);
        items_sent++;
    endtask

    // One register write transaction.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.apply_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every outstanding peak and let the phase unit drain.
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.awaiting.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random bits above a narrow register, which the block must drop.
    function automatic logic [31:0] pad(input logic [31:0] v, input int w);
        logic [31:0] keep;
        if (w >= 32 || $urandom_range(1) == 0) begin
            return v;
        end
        keep = (32'd1 << w) - 32'd1;
        return (v & keep) | ($urandom() & ~keep);
    endfunction

    task automatic set_config(input int n, input int g, input logic [31:0] th,
                              input int ce, input int up, input int lo);
        if ($urandom_range(1) == 1) begin
            cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
        end
        cfg_write(REG_FRAME_LENGTH, pad(n, LEN_W));
        cfg_write(REG_GUARD_BINS, pad(g, BIN_W));
        cfg_write(REG_POWER_THRESHOLD, th);
        cfg_write(REG_CUT_ENABLE, pad(ce, 1));
        cfg_write(REG_UPPER_POS_BIN, pad(up, LEN_W));
        cfg_write(REG_LOWER_NEG_BIN, pad(lo, LEN_W));
        cur_n = n;
    endtask

    // Sample values: full range, tiny (many ties), extremes, or moderate.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int amp);
        int v;
        case (amp)
            0: v = $urandom();
            1: v = int'($urandom_range(16)) - 8;
            2: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(4000)) - 2000;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_frame(input int len, input int amp);
        int k;
        for (k = 0; k < len; k++) begin
            send_bin(rand_sample(amp), rand_sample(amp), k == len - 1);
        end
    endtask

    initial begin
        int ph;
        int target;
        int len;
        int r;
        int n;
        int g;
        int up;
        int lo;
        logic [31:0] th;

        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings: zero power, full scale,
        // angle of half a turn, ties, and the four quadrants.
        send_bin(16'sd0, 16'sd0, 1'b1);
        send_bin(-16'sd32768, -16'sd32768, 1'b1);
        send_bin(16'sd32767, 16'sd0, 1'b0);
        send_bin(-16'sd32768, 16'sd0, 1'b1);
        send_bin(-16'sd32768, -16'sd1, 1'b1);
        send_bin(16'sd0, 16'sd32767, 1'b0);
        send_bin(16'sd0, -16'sd32768, 1'b1);
        send_bin(16'sd3, 16'sd4, 1'b0);
        send_bin(16'sd4, 16'sd3, 1'b0);
        send_bin(-16'sd5, 16'sd0, 1'b0);
        send_bin(16'sd0, 16'sd5, 1'b1);
        send_bin(16'sd1, 16'sd0, 1'b0);
        send_bin(16'sd0, 16'sd0, 1'b0);
        send_bin(16'sd32767, -16'sd32768, 1'b0);
        send_bin(-16'sd32768, 16'sd32767, 1'b0);
        send_bin(16'sd0, -16'sd1, 1'b1);
        send_bin(-16'sd1, 16'sd0, 1'b1);
        send_bin(16'sd7, -16'sd7, 1'b0);
        send_bin(-16'sd7, 16'sd7, 1'b1);
        settle();

        // Overlong frame: loud bins past the configured frame length must never win.
        set_config(LONG_FRAME_N, 0, 0, 0, 4096, 0);
        for (int k = 0; k < LONG_FRAME_BINS; k++) begin
            if (k >= LONG_FRAME_N) begin
                send_bin(-16'sd32768, -16'sd32768, k == LONG_FRAME_BINS - 1);
            end else begin
                send_bin(rand_sample(1), rand_sample(1), 1'b0);
            end
        end
        settle();

        // Random phases, each under its own register settings; the first few
        // pin the extremes of the registers.
        ph = 0;
        target = 0;
        r = items_sent;
        while (items_sent - r < RANDOM_ITEMS) begin
            case (ph)
                0: set_config(1, 0, 0, 0, 4096, 0);
                1: set_config(0, 0, 0, 0, 0, 0);
                2: set_config(4096, 2048, 0, 1, 0, 8191);
                3: set_config(8191, 4095, 32'hFFFF_FFFF, 1, 8191, 8191);
                4: set_config(16, 2, 32'h7FFF_FFFF, 1, 3, 12);
                5: set_config(32, 1, 100, 1, 8, 24);
                default: begin
                    case ($urandom_range(9))
                        0: n = 0;
                        1: n = 1;
                        2: n = 4096;
                        3: n = 8191;
                        4: n = $urandom_range(64, 300);
                        default: n = $urandom_range(2, 48);
                    endcase
                    case ($urandom_range(7))
                        0: g = 2048;
                        1: g = 4095;
                        2, 3: g = 0;
                        default: g = $urandom_range((n > 4096 ? 4096 : n) / 4 + 1);
                    endcase
                    case ($urandom_range(7))
                        0: th = 0;
                        1: th = 32'hFFFF_FFFF;
                        2: th = 32'h8000_0000;
                        3: th = $urandom_range(200);
                        4: th = $urandom();
                        default: th = $urandom_range(32'h1000_0000);
                    endcase
                    case ($urandom_range(3))
                        0: up = 0;
                        1: up = 8191;
                        default: up = $urandom_range(n > 4096 ? 4096 : n);
                    endcase
                    case ($urandom_range(3))
                        0: lo = 0;
                        1: lo = 8191;
                        default: lo = $urandom_range(up > 4097 ? 8191 : 4097, up);
                    endcase
                    set_config(n, g, th, $urandom_range(1), up, lo);
                end
            endcase
            steady = (items_sent - r >= 400) && (items_sent - r < 560);
            target = items_sent + $urandom_range(50, 110);
            while (items_sent < target) begin
                n = (cur_n > MAX_FRAME) ? MAX_FRAME : cur_n;
                case ($urandom_range(19))
                    0: len = $urandom_range(100, 300);
                    1, 2, 3, 4: len = (n >= 1 && n <= 300) ? n : $urandom_range(1, 24);
                    5, 6, 7, 8, 9: len = $urandom_range(1, 80);
                    default: len = $urandom_range(1, 24);
                endcase
                send_frame(len, $urandom_range(3));
            end
            settle();
            ph++;
        end
        steady = 1'b0;
        settle();

        if (sb.awaiting.size() != 0) begin
            sb.flag($sformatf("%0d peak results never arrived", sb.awaiting.size()));
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/smpf_pkg.sv
src/smpf_front.sv
src/smpf_queue.sv
src/smpf_back.sv
src/spectrum_max_peak_finder.sv
test/tb.sv
